// ----- rtl/core/spq_pkg.sv -----
package spq_pkg;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	typedef struct packed {
		logic        func;
		logic [3:0]  key_severity;
		logic [31:0] key_arrival;
		logic [15:0] entry_tag;
	} item_t;

	typedef struct packed {
		logic        ok;
		logic [3:0]  out_severity;
		logic [31:0] out_arrival;
		logic [15:0] out_tag;
		logic [6:0]  occupancy;
		logic        is_empty;
		logic        is_full;
	} result_t;

	typedef struct packed {
		logic [3:0]  severity;
		logic [31:0] arrival;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic ld_ins;
		logic rd_head;
		logic shift;
		logic put;
		logic fin;
		logic fin_ok;
		logic fin_deq;
		logic cnt_inc;
		logic cnt_dec;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic left_one;
		logic behind;
	} stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_DEQ_RD
	} state_t;

endpackage

// ----- rtl/core/spq_ctrl.sv -----
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              func,
	input  spq_pkg::stat_t    stat,
	output spq_pkg::cmd_t     cmd,
	output logic              busy
);

	spq_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (start) begin
					if (func == spq_pkg::FUNC_DEQ) begin
						if (!stat.empty) begin
							state_nxt = spq_pkg::ST_DEQ_RD;
						end
					end else if (!stat.full) begin
						state_nxt = stat.empty ? spq_pkg::ST_INS_PUT : spq_pkg::ST_INS_CMP;
					end
				end
			end
			spq_pkg::ST_INS_CMP: begin
				if (stat.behind) begin
					state_nxt = stat.left_one ? spq_pkg::ST_INS_PUT : spq_pkg::ST_INS_CMP;
				end else begin
					state_nxt = spq_pkg::ST_IDLE;
				end
			end
			spq_pkg::ST_INS_PUT: state_nxt = spq_pkg::ST_IDLE;
			spq_pkg::ST_DEQ_RD:  state_nxt = spq_pkg::ST_IDLE;
			default:             state_nxt = spq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = (state_q != spq_pkg::ST_IDLE);
		unique case (state_q)
			spq_pkg::ST_IDLE: begin
				if (start) begin
					if (func == spq_pkg::FUNC_DEQ) begin
						if (stat.empty) begin
							cmd.fin = 1'b1;
						end else begin
							cmd.rd_head = 1'b1;
						end
					end else if (stat.full) begin
						cmd.fin = 1'b1;
					end else begin
						cmd.ld_ins = 1'b1;
					end
				end
			end
			spq_pkg::ST_INS_CMP: begin
				if (stat.behind) begin
					cmd.shift = 1'b1;
				end else begin
					cmd.put     = 1'b1;
					cmd.fin     = 1'b1;
					cmd.fin_ok  = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			spq_pkg::ST_INS_PUT: begin
				cmd.put     = 1'b1;
				cmd.fin     = 1'b1;
				cmd.fin_ok  = 1'b1;
				cmd.cnt_inc = 1'b1;
			end
			spq_pkg::ST_DEQ_RD: begin
				cmd.fin     = 1'b1;
				cmd.fin_ok  = 1'b1;
				cmd.fin_deq = 1'b1;
				cmd.cnt_dec = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- rtl/core/spq_dp.sv -----
module spq_dp #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  spq_pkg::item_t      item,
	input  spq_pkg::cmd_t       cmd,
	output spq_pkg::stat_t      stat,
	output spq_pkg::result_t    result,
	output logic                done
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	spq_pkg::entry_t mem [DEPTH];
	spq_pkg::entry_t rd_data_q;
	spq_pkg::entry_t ins_q;
	spq_pkg::result_t result_q;
	logic            done_q;

	logic [IW-1:0] head_q, pos_q, prv_q;
	logic [CW-1:0] count_q, left_q;
	logic [IW-1:0] rd_addr, tail, tail_prv, prv_prv, head_nxt;
	logic [IW:0]   tail_sum;
	logic [CW-1:0] cnt_next;

	function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] idx);
		return (idx == '0) ? IW'(DEPTH - 1) : idx - 1'b1;
	endfunction

	always_comb begin
		tail_sum = {1'b0, head_q} + (IW + 1)'(count_q);
		if (tail_sum >= (IW + 1)'(DEPTH)) begin
			tail = IW'(tail_sum - (IW + 1)'(DEPTH));
		end else begin
			tail = tail_sum[IW-1:0];
		end
		tail_prv = idx_prev(tail);
		prv_prv  = idx_prev(prv_q);
		head_nxt = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
		if (cmd.rd_head) begin
			rd_addr = head_q;
		end else if (cmd.ld_ins) begin
			rd_addr = tail_prv;
		end else begin
			rd_addr = prv_prv;
		end
		if (cmd.cnt_inc) begin
			cnt_next = count_q + 1'b1;
		end else if (cmd.cnt_dec) begin
			cnt_next = count_q - 1'b1;
		end else begin
			cnt_next = count_q;
		end
	end

	assign stat.full     = (count_q == CW'(DEPTH));
	assign stat.empty    = (count_q == '0);
	assign stat.left_one = (left_q == CW'(1));
	assign stat.behind   = (rd_data_q.severity > ins_q.severity) ||
	                       ((rd_data_q.severity == ins_q.severity) &&
	                        (rd_data_q.arrival > ins_q.arrival));

	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			mem[pos_q] <= rd_data_q;
		end else if (cmd.put) begin
			mem[pos_q] <= ins_q;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_ins) begin
			ins_q.severity <= item.key_severity;
			ins_q.arrival  <= item.key_arrival;
			ins_q.tag      <= item.entry_tag;
			pos_q          <= tail;
			prv_q          <= tail_prv;
			left_q         <= count_q;
		end else if (cmd.shift) begin
			pos_q  <= prv_q;
			prv_q  <= prv_prv;
			left_q <= left_q - 1'b1;
		end
		if (cmd.fin) begin
			result_q.ok           <= cmd.fin_ok;
			result_q.out_severity <= cmd.fin_deq ? rd_data_q.severity : '0;
			result_q.out_arrival  <= cmd.fin_deq ? rd_data_q.arrival : '0;
			result_q.out_tag      <= cmd.fin_deq ? rd_data_q.tag : '0;
			result_q.occupancy    <= 7'(cnt_next);
			result_q.is_empty     <= (cnt_next == '0);
			result_q.is_full      <= (cnt_next == CW'(DEPTH));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.fin;
			if (cmd.fin) begin
				count_q <= cnt_next;
				if (cmd.cnt_dec) begin
					head_q <= head_nxt;
				end
			end
		end
	end

	assign result = result_q;
	assign done   = done_q;

endmodule

// ----- rtl/core/sorted_priority_queue.sv -----
// Bounded priority queue kept sorted by severity, then arrival time, with
// equal keys leaving in the order they came in. A beat on the item port is
// taken at a clock edge where start is high and busy is low; func selects
// enqueue or dequeue. Each item produces exactly one result beat, shown on
// the result port for one cycle while done is high; the receiver cannot stall
// it, so it must take every beat as it appears.
// The entries sit in a single-port-write, registered-read memory used as a
// ring, so a dequeue only advances the head: the head entry is read into a
// register, then registered onto the result port. An enqueue walks from the
// tail toward the head, moving one entry back per cycle until it finds its
// slot, and then writes itself into that slot.
// A refused enqueue (full) or dequeue (empty) answers in the cycle after acceptance.
// busy falls in the cycle the result is shown, so a new item may be taken
// then. Reset empties the queue at once; no clearing pass is needed because
// only entries that were written are ever used.
module sorted_priority_queue #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  spq_pkg::item_t     item,
	output spq_pkg::result_t   result,
	output logic               done
);

	spq_pkg::cmd_t  cmd;
	spq_pkg::stat_t stat;

	spq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.func   (item.func),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	spq_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result),
		.done   (done)
	);

	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.func == spq_pkg::FUNC_ENQ && stat.full)
		|=> (done && !result.ok))
		else $error("enqueue into a full queue was not refused");

	a_empty_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && item.func == spq_pkg::FUNC_DEQ && stat.empty)
		|=> (done && !result.ok && result.out_tag == '0))
		else $error("dequeue from an empty queue was not refused");

	a_one_move: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ld_ins, cmd.rd_head, cmd.shift, cmd.put}))
		else $error("datapath given conflicting commands");

	a_count_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(stat.full && stat.empty))
		else $error("queue count reports both full and empty");

endmodule

// ----- dv/sorted_priority_queue_check.sv -----
`timescale 1ns / 1ps

module sorted_priority_queue_check
	import spq_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  logic    busy,
	input  item_t   item,
	input  result_t result,
	input  logic    done,
	output int      fails,
	output int      pending
);

	entry_t  held [DEPTH];
	int      held_count;
	result_t due_results [$];
	result_t want;
	int      beat_index;

	function automatic result_t apply_queue_op(item_t it);
		result_t r;
		int      pos;
		int      i;
		r = '0;
		if (it.func == FUNC_ENQ) begin
			if (held_count < DEPTH) begin
				pos = held_count;
				while (pos > 0 && (held[pos-1].severity > it.key_severity ||
						(held[pos-1].severity == it.key_severity &&
						 held[pos-1].arrival > it.key_arrival))) begin
					held[pos] = held[pos-1];
					pos--;
				end
				held[pos].severity = it.key_severity;
				held[pos].arrival  = it.key_arrival;
				held[pos].tag      = it.entry_tag;
				held_count++;
				r.ok = 1'b1;
			end
		end else if (held_count > 0) begin
			r.ok           = 1'b1;
			r.out_severity = held[0].severity;
			r.out_arrival  = held[0].arrival;
			r.out_tag      = held[0].tag;
			for (i = 1; i < held_count; i++) begin
				held[i-1] = held[i];
			end
			held_count--;
		end
		r.occupancy = 7'(held_count);
		r.is_empty  = (held_count == 0);
		r.is_full   = (held_count == DEPTH);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (fails < 100) begin
			$display("%0t ns: result beat %0d: %s is %0h, predicted %0h",
				$time, beat_index, what, got, exp_val);
		end
		fails++;
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		if (got !== exp_val) begin
			report_mismatch(what, got, exp_val);
		end
	endtask

	initial begin
		fails      = 0;
		pending    = 0;
		held_count = 0;
		beat_index = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_count = 0;
			due_results.delete();
			pending = 0;
		end else begin
			if (done) begin
				if (due_results.size() == 0) begin
					report_mismatch("unexpected result beat, ok", 32'(result.ok), 32'h0);
				end else begin
					want = due_results.pop_front();
					compare_field("ok", 32'(result.ok), 32'(want.ok));
					compare_field("out_severity", 32'(result.out_severity),
						32'(want.out_severity));
					compare_field("out_arrival", result.out_arrival, want.out_arrival);
					compare_field("out_tag", 32'(result.out_tag), 32'(want.out_tag));
					compare_field("occupancy", 32'(result.occupancy), 32'(want.occupancy));
					compare_field("is_empty", 32'(result.is_empty), 32'(want.is_empty));
					compare_field("is_full", 32'(result.is_full), 32'(want.is_full));
				end
				beat_index++;
			end
			if (start && !busy) begin
				due_results.push_back(apply_queue_op(item));
			end
			pending = due_results.size();
		end
	end

endmodule

// ----- dv/sorted_priority_queue_test.sv -----
`timescale 1ns / 1ps

module sorted_priority_queue_test;
	import spq_pkg::*;

	localparam int DEPTH      = 64;
	localparam int ITEM_COUNT = 1900;
	localparam int IDLE_LIMIT = 2000;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	item_t   item;
	result_t result;
	logic    done;
	int      fails;
	int      pending;
	int      idle_cycles;
	int      burst_left;

	sorted_priority_queue #(
		.DEPTH(DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.item  (item),
		.result(result),
		.done  (done)
	);

	sorted_priority_queue_check #(
		.DEPTH(DEPTH)
	) checker_inst (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.result (result),
		.done   (done),
		.fails  (fails),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Any cycle that moves a beat in either direction counts as progress.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL sorted_priority_queue");
				$finish;
			end
		end
	end

	function automatic item_t make_item(input logic op, input logic [3:0] sev,
			input logic [31:0] arr, input logic [15:0] tag);
		item_t it;
		it.func         = op;
		it.key_severity = sev;
		it.key_arrival  = arr;
		it.entry_tag    = tag;
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int   gap;
		logic was_busy;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		start <= 1'b1;
		item  <= it;
		do begin
			@(negedge clk);
			was_busy = busy;
			@(posedge clk);
		end while (was_busy);
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int          sent;
		int          phase_len;
		int          enq_pct;
		int          key_mode;
		int          n;
		logic        op;
		logic [3:0]  sev;
		logic [31:0] arr;

		arst_n      <= 1'b0;
		start       <= 1'b0;
		item        <= '0;
		idle_cycles <= 0;
		burst_left  = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Refused dequeue on an empty queue, field extremes, equal keys that must
		// leave in insertion order, then a drain past empty.
		send_item(make_item(FUNC_DEQ, 4'hf, 32'hffff_ffff, 16'hffff));
		send_item(make_item(FUNC_ENQ, 4'hf, 32'hffff_ffff, 16'hffff));
		send_item(make_item(FUNC_ENQ, 4'h0, 32'h0, 16'h0));
		send_item(make_item(FUNC_ENQ, 4'h5, 32'd100, 16'd1));
		send_item(make_item(FUNC_ENQ, 4'h5, 32'd100, 16'd2));
		send_item(make_item(FUNC_ENQ, 4'h5, 32'd100, 16'd3));
		send_item(make_item(FUNC_ENQ, 4'h5, 32'd99, 16'd4));
		send_item(make_item(FUNC_ENQ, 4'hf, 32'h0, 16'd5));
		send_item(make_item(FUNC_ENQ, 4'h0, 32'hffff_ffff, 16'd6));
		send_item(make_item(FUNC_ENQ, 4'h5, 32'd100, 16'd7));
		for (n = 0; n < 11; n++) begin
			send_item(make_item(FUNC_DEQ, 4'h0, 32'h0, 16'h0));
		end
		wait_drained();

		// Phases lean toward filling, draining, or mixing, so the queue keeps
		// running into both its full and its empty limits.
		sent = 0;
		while (sent < ITEM_COUNT) begin
			case ($urandom_range(0, 3))
				0:       enq_pct = 90;
				1:       enq_pct = 12;
				2:       enq_pct = 50;
				default: enq_pct = 62;
			endcase
			key_mode  = $urandom_range(0, 2);
			phase_len = $urandom_range(40, 140);
			for (n = 0; n < phase_len; n++) begin
				op = ($urandom_range(1, 100) <= enq_pct) ? FUNC_ENQ : FUNC_DEQ;
				case (key_mode)
					0: begin
						sev = 4'($urandom_range(0, 15));
						arr = $urandom();
					end
					1: begin
						sev = $urandom_range(0, 1) ? 4'h3 : 4'hc;
						arr = 32'($urandom_range(0, 3));
					end
					default: begin
						sev = 4'($urandom_range(0, 15));
						arr = $urandom_range(0, 1) ? 32'($urandom_range(0, 40)) :
							$urandom();
					end
				endcase
				send_item(make_item(op, sev, arr, 16'($urandom())));
				sent++;
			end
			if ($urandom_range(0, 3) == 0) begin
				wait_drained();
			end
		end

		wait_drained();
		repeat (80) @(posedge clk);
		if (fails == 0) begin
			$display("PASS sorted_priority_queue");
		end else begin
			$display("FAIL sorted_priority_queue");
		end
		$finish;
	end

endmodule
